// File: rtl/byte_range_coverage_tracker_top_defines.svh
// assertion macros for the byte range coverage tracker checker
// no dependencies; included by the checker file only
`ifndef BYTE_RANGE_COVERAGE_TRACKER_TOP_DEFINES_SVH
`define BYTE_RANGE_COVERAGE_TRACKER_TOP_DEFINES_SVH

// same-cycle implication under synchronous active-low reset
`define BRC_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication under synchronous active-low reset
`define BRC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/brc_pkg.sv
// shared constants, command codes and unit result type for the coverage tracker
// no dependencies
`default_nettype none
package brc_pkg;

    localparam int MAX_RANGES_DEF  = 16;
    localparam int OFFSET_BITS_DEF = 48;

    localparam int FIELD_W = 48;
    localparam logic [FIELD_W-1:0] FIELD_MAX = {FIELD_W{1'b1}};

    localparam logic [2:0] CMD_ADD    = 3'd0;
    localparam logic [2:0] CMD_CHECK  = 3'd1;
    localparam logic [2:0] CMD_CLEAR  = 3'd2;
    localparam logic [2:0] CMD_LOCK   = 3'd3;
    localparam logic [2:0] CMD_UNLOCK = 3'd4;

    localparam logic [7:0] LOCK_MAX = 8'd255;

    // what the shared unit says about one stored entry
    typedef struct packed {
        logic               touch;    // overlaps or abuts the query range
        logic               below;    // lies wholly below the query range, with a gap
        logic               hit;      // holds either end byte of the query
        logic [FIELD_W-1:0] sum_next; // running total plus this entry, saturated
    } t_unit_res;

endpackage
`default_nettype wire

// File: rtl/brc_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
`default_nettype none
module brc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

// File: rtl/brc_unit.sv
// shared compare and accumulate unit applied to one stored range per use
// depends on brc_pkg
`default_nettype none
module brc_unit #(
    parameter int PW = brc_pkg::OFFSET_BITS_DEF
) (
    input  wire logic [PW-1:0]               i_first,
    input  wire logic [PW-1:0]               i_last,
    input  wire logic [PW-1:0]               i_qfirst,
    input  wire logic [PW-1:0]               i_qlast,
    input  wire logic [brc_pkg::FIELD_W-1:0] i_sum,
    output brc_pkg::t_unit_res               o_res
);

    localparam int SW = ((PW > brc_pkg::FIELD_W) ? PW : brc_pkg::FIELD_W) + 2;

    logic          lo_ok;
    logic          hi_ok;
    logic [SW-1:0] sum_wide;

    always_comb begin
        lo_ok = ({1'b0, i_last} + (PW+1)'(1)) >= {1'b0, i_qfirst};
        hi_ok = {1'b0, i_first} <= ({1'b0, i_qlast} + (PW+1)'(1));
        sum_wide = SW'(i_sum) + SW'(i_last - i_first) + SW'(1);
        o_res.touch  = lo_ok && hi_ok;
        o_res.below  = !lo_ok;
        o_res.hit    = (i_first <= i_qfirst && i_qfirst <= i_last) ||
                       (i_first <= i_qlast && i_qlast <= i_last);
        o_res.sum_next = (sum_wide > SW'(brc_pkg::FIELD_MAX)) ? brc_pkg::FIELD_MAX
                                                               : sum_wide[brc_pkg::FIELD_W-1:0];
    end

endmodule
`default_nettype wire

// File: rtl/byte_range_coverage_tracker_top.sv
// byte range coverage tracker: sequencer, range ram and shared compare unit
// depends on brc_pkg, brc_ram, brc_unit
//
//  channel | valid       | ready       | payload
//  --------+-------------+-------------+------------------------------------------
//  input   | i_in_valid  | o_in_ready  | i_cmd, i_offset, i_length
//  output  | o_out_valid | i_out_ready | o_found .. o_unlock_error
//  config  | i_cfg_valid | o_cfg_ready | i_cfg_data (total_size)
//
// each entry visit is a read state then an evaluate state, through the single ram read port
// and the shared unit. add: scan, plan, move entries to open a gap or close a hole, write the
// merged range, recount; a full table with nothing touched ends after the scan. check: scan
// only; zero-length add and others go straight to done, which waits while the result is unread.
// reset empties the table at once; the ram holds no reset contents and needs no sweep.
// a finished result waits in the output register while the next transaction is taken.
`default_nettype none
module byte_range_coverage_tracker_top #(
    parameter int MAX_RANGES  = brc_pkg::MAX_RANGES_DEF,
    parameter int OFFSET_BITS = brc_pkg::OFFSET_BITS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [2:0]  i_cmd,
    input  wire logic [47:0] i_offset,
    input  wire logic [47:0] i_length,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic             o_found,
    output logic             o_complete,
    output logic [47:0]      o_covered_bytes,
    output logic [4:0]       o_entries_used,
    output logic             o_table_full,
    output logic             o_unlock_error,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [47:0] i_cfg_data
);

    localparam int PW  = OFFSET_BITS;
    localparam int CW  = $clog2(MAX_RANGES + 1);
    localparam int AW  = $clog2(MAX_RANGES);
    localparam int XW  = (PW > 50) ? PW : 50;
    localparam int TW  = ((PW > 48) ? PW : 48) + 1;

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_SCAN_RD = 4'd1;
    localparam logic [3:0] S_SCAN_EV = 4'd2;
    localparam logic [3:0] S_PLAN    = 4'd3;
    localparam logic [3:0] S_SH_RD   = 4'd4;
    localparam logic [3:0] S_SH_WR   = 4'd5;
    localparam logic [3:0] S_MERGE   = 4'd6;
    localparam logic [3:0] S_FIN     = 4'd7;
    localparam logic [3:0] S_CNT_RD  = 4'd8;
    localparam logic [3:0] S_CNT_EV  = 4'd9;
    localparam logic [3:0] S_DONE    = 4'd10;

    logic [3:0]    r_state, n_state;
    logic [2:0]    r_cmd, n_cmd;
    logic [PW-1:0] r_qf, n_qf, r_ql, n_ql;
    logic [PW-1:0] r_mf, n_mf, r_ml, n_ml;
    logic [CW-1:0] r_idx, n_idx, r_t, n_t, r_k, n_k, r_cnt, n_cnt;
    logic          r_up, n_up;
    logic          r_hit, n_hit, r_full, n_full, r_uerr, n_uerr;
    logic [47:0]   r_sum, n_sum, r_cov, n_cov, r_total, n_total;
    logic [7:0]    r_lock, n_lock;
    logic [PW-1:0] r_head_f, n_head_f, r_head_l, n_head_l;

    logic          n_out_valid, n_found, n_complete, n_table_full, n_unlock_error;
    logic [47:0]   n_covered_bytes;
    logic [4:0]    n_entries_used;

    logic            ram_we;
    logic [CW-1:0]   ram_waddr;
    logic [2*PW-1:0] ram_wdata, ram_rdata;
    logic [PW-1:0]   ent_f, ent_l;

    logic [PW-1:0] off_m, end_in;
    logic [XW-1:0] end_wide;
    logic          head_ok, complete_now, last_idx;
    logic [CW-1:0] dest_dn;

    brc_pkg::t_unit_res unit_res;

    assign ent_f = ram_rdata[2*PW-1:PW];
    assign ent_l = ram_rdata[PW-1:0];

    brc_ram #(.WIDTH(2*PW), .DEPTH(MAX_RANGES)) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr[AW-1:0]),
        .i_wdata (ram_wdata),
        .i_raddr (r_idx[AW-1:0]),
        .o_rdata (ram_rdata)
    );

    brc_unit #(.PW(PW)) u_unit (
        .i_first  (ent_f),
        .i_last   (ent_l),
        .i_qfirst (r_qf),
        .i_qlast  (r_ql),
        .i_sum    (r_sum),
        .o_res    (unit_res)
    );

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;

    always_comb begin
        // end byte, clipped to the highest offset
        off_m    = PW'(i_offset);
        end_wide = XW'(off_m) + XW'(i_length) - XW'(1);
        if (i_length == '0) begin
            end_in = off_m;
        end else if (end_wide > XW'({PW{1'b1}})) begin
            end_in = {PW{1'b1}};
        end else begin
            end_in = PW'(end_wide);
        end

        head_ok = (TW'(r_head_l) + TW'(1)) >= TW'(r_total);
        complete_now = (r_lock <= 8'd1) &&
                       ((r_total == '0) || (r_cnt == CW'(1) && r_head_f == '0 && head_ok));
        last_idx = (CW'(r_idx + CW'(1)) == r_cnt);
        dest_dn  = CW'(r_idx - r_t + CW'(1));
    end

    always_comb begin
        n_state = r_state;
        n_cmd = r_cmd;
        n_qf = r_qf;
        n_ql = r_ql;
        n_mf = r_mf;
        n_ml = r_ml;
        n_idx = r_idx;
        n_t = r_t;
        n_k = r_k;
        n_cnt = r_cnt;
        n_up = r_up;
        n_hit = r_hit;
        n_full = r_full;
        n_uerr = r_uerr;
        n_sum = r_sum;
        n_cov = r_cov;
        n_lock = r_lock;
        n_total = r_total;
        n_head_f = r_head_f;
        n_head_l = r_head_l;
        n_out_valid = o_out_valid;
        n_found = o_found;
        n_complete = o_complete;
        n_covered_bytes = o_covered_bytes;
        n_entries_used = o_entries_used;
        n_table_full = o_table_full;
        n_unlock_error = o_unlock_error;
        ram_we = 1'b0;
        ram_waddr = r_k;
        ram_wdata = {r_mf, r_ml};

        if (o_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        if (i_cfg_valid) begin
            n_total = i_cfg_data;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_cmd = i_cmd;
                    n_qf = off_m;
                    n_ql = end_in;
                    n_mf = off_m;
                    n_ml = end_in;
                    n_hit = 1'b0;
                    n_full = 1'b0;
                    n_uerr = 1'b0;
                    n_idx = '0;
                    n_t = '0;
                    n_k = '0;
                    n_state = S_DONE;
                    unique case (i_cmd)
                        brc_pkg::CMD_ADD: begin
                            if (i_length != '0) begin
                                n_state = (r_cnt == '0) ? S_PLAN : S_SCAN_RD;
                            end
                        end
                        brc_pkg::CMD_CHECK: begin
                            if (r_cnt != '0) begin
                                n_state = S_SCAN_RD;
                            end
                        end
                        brc_pkg::CMD_CLEAR: begin
                            n_cnt = '0;
                            n_cov = '0;
                        end
                        brc_pkg::CMD_LOCK: begin
                            if (r_lock != brc_pkg::LOCK_MAX) begin
                                n_lock = r_lock + 8'd1;
                            end
                        end
                        brc_pkg::CMD_UNLOCK: begin
                            if (r_lock == '0) begin
                                n_uerr = 1'b1;
                            end else begin
                                n_lock = r_lock - 8'd1;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_SCAN_RD: begin
                n_state = S_SCAN_EV;
            end
            S_SCAN_EV: begin
                if (r_cmd == brc_pkg::CMD_ADD) begin
                    if (unit_res.touch) begin
                        n_t = r_t + CW'(1);
                        if (ent_f < r_mf) n_mf = ent_f;
                        if (ent_l > r_ml) n_ml = ent_l;
                    end
                    if (unit_res.below) begin
                        n_k = r_k + CW'(1);
                    end
                end else begin
                    n_hit = r_hit | unit_res.hit;
                end
                n_idx = r_idx + CW'(1);
                if (last_idx) begin
                    n_state = (r_cmd == brc_pkg::CMD_ADD) ? S_PLAN : S_DONE;
                end else begin
                    n_state = S_SCAN_RD;
                end
            end
            S_PLAN: begin
                n_up = (r_t == '0);
                if (r_t == '0 && r_cnt >= CW'(MAX_RANGES)) begin
                    n_full = 1'b1;
                    n_state = S_DONE;
                end else if (r_t == '0 && r_cnt > r_k) begin
                    // open a gap at the insertion point, top entry first
                    n_idx = r_cnt - CW'(1);
                    n_state = S_SH_RD;
                end else begin
                    n_state = S_MERGE;
                end
            end
            S_SH_RD: begin
                n_state = S_SH_WR;
            end
            S_SH_WR: begin
                ram_we = 1'b1;
                ram_wdata = ram_rdata;
                ram_waddr = r_up ? CW'(r_idx + CW'(1)) : dest_dn;
                if (r_up) begin
                    if (r_idx == r_k) begin
                        n_state = S_MERGE;
                    end else begin
                        n_idx = r_idx - CW'(1);
                        n_state = S_SH_RD;
                    end
                end else begin
                    n_idx = r_idx + CW'(1);
                    n_state = last_idx ? S_FIN : S_SH_RD;
                end
            end
            S_MERGE: begin
                ram_we = 1'b1;
                if (!r_up && r_t > CW'(1) && CW'(r_k + r_t) < r_cnt) begin
                    // close the hole left by the absorbed ranges
                    n_idx = CW'(r_k + r_t);
                    n_state = S_SH_RD;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                n_cnt = r_up ? CW'(r_cnt + CW'(1)) : CW'(r_cnt - r_t + CW'(1));
                n_idx = '0;
                n_sum = '0;
                n_state = S_CNT_RD;
            end
            S_CNT_RD: begin
                n_state = S_CNT_EV;
            end
            S_CNT_EV: begin
                n_sum = unit_res.sum_next;
                n_idx = r_idx + CW'(1);
                if (last_idx) begin
                    n_cov = unit_res.sum_next;
                    n_state = S_DONE;
                end else begin
                    n_state = S_CNT_RD;
                end
            end
            S_DONE: begin
                if (!o_out_valid || i_out_ready) begin
                    n_out_valid = 1'b1;
                    n_found = r_hit;
                    n_complete = complete_now;
                    n_covered_bytes = r_cov;
                    n_entries_used = 5'(r_cnt);
                    n_table_full = r_full;
                    n_unlock_error = r_uerr;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // keep a copy of the lowest entry for the completeness test
        if (ram_we && ram_waddr == '0) begin
            n_head_f = ram_wdata[2*PW-1:PW];
            n_head_l = ram_wdata[PW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt <= '0;
            r_cov <= '0;
            r_lock <= '0;
            r_total <= '0;
            o_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt <= n_cnt;
            r_cov <= n_cov;
            r_lock <= n_lock;
            r_total <= n_total;
            o_out_valid <= n_out_valid;
        end
        r_cmd <= n_cmd;
        r_qf <= n_qf;
        r_ql <= n_ql;
        r_mf <= n_mf;
        r_ml <= n_ml;
        r_idx <= n_idx;
        r_t <= n_t;
        r_k <= n_k;
        r_up <= n_up;
        r_hit <= n_hit;
        r_full <= n_full;
        r_uerr <= n_uerr;
        r_sum <= n_sum;
        r_head_f <= n_head_f;
        r_head_l <= n_head_l;
        o_found <= n_found;
        o_complete <= n_complete;
        o_covered_bytes <= n_covered_bytes;
        o_entries_used <= n_entries_used;
        o_table_full <= n_table_full;
        o_unlock_error <= n_unlock_error;
    end

endmodule
`default_nettype wire

// File: rtl/brc_checker.sv
// port-level checker for the coverage tracker, bound to the top level
// depends on brc_pkg, byte_range_coverage_tracker_top_defines.svh and the top level
`default_nettype none
`include "byte_range_coverage_tracker_top_defines.svh"
module brc_checker #(
    parameter int MAX_RANGES = brc_pkg::MAX_RANGES_DEF
) (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_in_valid,
    input wire logic       o_in_ready,
    input wire logic       o_out_valid,
    input wire logic       i_out_ready,
    input wire logic       o_found,
    input wire logic [4:0] o_entries_used,
    input wire logic       o_table_full,
    input wire logic       o_unlock_error
);

    `BRC_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid, "result dropped while stalled")
    `BRC_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_in_valid && o_in_ready, !o_in_ready, "second transaction taken while busy")
    `BRC_ASSERT_NOW(a_full_count, i_clk, i_rst_n, o_out_valid && o_table_full, o_entries_used == 5'(MAX_RANGES), "table full flagged below capacity")
    `BRC_ASSERT_NOW(a_flags_exclusive, i_clk, i_rst_n, o_out_valid, $countones({o_found, o_table_full, o_unlock_error}) <= 1, "flags of different commands together")

endmodule

bind byte_range_coverage_tracker_top brc_checker #(.MAX_RANGES(MAX_RANGES)) u_brc_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in_valid),
    .o_in_ready     (o_in_ready),
    .o_out_valid    (o_out_valid),
    .i_out_ready    (i_out_ready),
    .o_found        (o_found),
    .o_entries_used (o_entries_used),
    .o_table_full   (o_table_full),
    .o_unlock_error (o_unlock_error)
);
`default_nettype wire

// File: verif/byte_range_coverage_tracker_checker.sv
// checker for the byte range coverage tracker: mirrors the range table and compares results
// depends on brc_pkg; instantiated beside the block by byte_range_coverage_tracker_top_tb
`default_nettype none
module byte_range_coverage_tracker_checker (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    input  wire logic        i_in_ready,
    input  wire logic [2:0]  i_cmd,
    input  wire logic [47:0] i_offset,
    input  wire logic [47:0] i_length,
    input  wire logic        i_out_valid,
    input  wire logic        i_out_ready,
    input  wire logic        i_found,
    input  wire logic        i_complete,
    input  wire logic [47:0] i_covered_bytes,
    input  wire logic [4:0]  i_entries_used,
    input  wire logic        i_table_full,
    input  wire logic        i_unlock_error,
    input  wire logic        i_cfg_valid,
    input  wire logic        i_cfg_ready,
    input  wire logic [47:0] i_cfg_data,
    output int               o_fail_count,
    output int               o_pending
);

    localparam int NR = brc_pkg::MAX_RANGES_DEF;
    localparam logic [47:0] TOP = brc_pkg::FIELD_MAX;

    typedef struct packed {
        logic        found;
        logic        complete;
        logic [47:0] covered;
        logic [4:0]  entries;
        logic        full;
        logic        uerr;
    } t_status;

    logic [47:0] span_lo[NR];
    logic [47:0] span_hi[NR];
    int          n_spans;
    logic [47:0] covered_sum;
    logic [7:0]  lock_depth;
    logic [47:0] object_size;
    t_status     expected_q[$];

    function automatic logic [47:0] last_byte(logic [47:0] off, logic [47:0] len);
        logic [48:0] e;
        if (len == 0) return off;
        e = {1'b0, off} + {1'b0, len} - 49'd1;
        return e[48] ? TOP : e[47:0];
    endfunction

    function automatic logic span_complete();
        if (lock_depth > 1) return 1'b0;
        if (object_size == 0) return 1'b1;
        return n_spans == 1 && span_lo[0] == 0 && span_hi[0] >= object_size - 1;
    endfunction

    // union of the new range with every touching span, then ordered insert
    function automatic logic merge_span(logic [47:0] f, logic [47:0] l);
        logic [47:0] nf[NR+1];
        logic [47:0] nl[NR+1];
        logic [47:0] mf, ml;
        logic [48:0] sum;
        int k, m, touched;
        logic placed;
        mf = f; ml = l; touched = 0; m = 0; placed = 0;
        for (k = 0; k < n_spans; k++)
            if ((f == 0 || span_hi[k] >= f - 1) && (span_lo[k] == 0 || span_lo[k] - 1 <= l)) begin
                touched++;
                if (span_lo[k] < mf) mf = span_lo[k];
                if (span_hi[k] > ml) ml = span_hi[k];
            end
        if (touched == 0 && n_spans >= NR) return 1'b1;
        for (k = 0; k < n_spans; k++) begin
            if (span_lo[k] >= mf && span_hi[k] <= ml) continue;
            if (!placed && span_lo[k] > ml) begin
                nf[m] = mf; nl[m] = ml; m++; placed = 1;
            end
            nf[m] = span_lo[k]; nl[m] = span_hi[k]; m++;
        end
        if (!placed) begin
            nf[m] = mf; nl[m] = ml; m++;
        end
        n_spans = m;
        sum = 0;
        for (k = 0; k < m; k++) begin
            span_lo[k] = nf[k];
            span_hi[k] = nl[k];
            sum = sum + {1'b0, nl[k] - nf[k]} + 49'd1;
            if (sum > {1'b0, TOP}) sum = {1'b0, TOP};
        end
        covered_sum = sum[47:0];
        return 1'b0;
    endfunction

    function automatic t_status apply_command(logic [2:0] cmd, logic [47:0] off,
                                              logic [47:0] len);
        t_status r;
        logic [47:0] e;
        r = '0;
        e = last_byte(off, len);
        case (cmd)
            brc_pkg::CMD_ADD: if (len != 0) r.full = merge_span(off, e);
            brc_pkg::CMD_CHECK: begin
                for (int k = 0; k < n_spans; k++)
                    if ((span_lo[k] <= off && off <= span_hi[k]) ||
                        (span_lo[k] <= e && e <= span_hi[k])) r.found = 1'b1;
            end
            brc_pkg::CMD_CLEAR: begin
                n_spans = 0;
                covered_sum = 0;
            end
            brc_pkg::CMD_LOCK: if (lock_depth != brc_pkg::LOCK_MAX) lock_depth++;
            brc_pkg::CMD_UNLOCK: begin
                if (lock_depth == 0) r.uerr = 1'b1;
                else lock_depth--;
            end
            default: ;
        endcase
        r.complete = span_complete();
        r.covered  = covered_sum;
        r.entries  = n_spans[4:0];
        return r;
    endfunction

    assign o_pending = expected_q.size();

    always @(posedge i_clk) begin
        t_status exp_r;
        t_status got;
        if (!i_rst_n) begin
            n_spans      = 0;
            covered_sum  = '0;
            lock_depth   = '0;
            object_size  = '0;
            o_fail_count <= 0;
            expected_q.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) object_size = i_cfg_data;
            if (i_out_valid && i_out_ready) begin
                got = {i_found, i_complete, i_covered_bytes, i_entries_used,
                       i_table_full, i_unlock_error};
                if (expected_q.size() == 0) begin
                    $display("%0t: result with nothing expected, got %h", $time, got);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    exp_r = expected_q.pop_front();
                    if (got !== exp_r) begin
                        $display("%0t: mismatch expected found=%b complete=%b covered=%h entries=%0d full=%b uerr=%b",
                                 $time, exp_r.found, exp_r.complete, exp_r.covered,
                                 exp_r.entries, exp_r.full, exp_r.uerr);
                        $display("%0t:          actual found=%b complete=%b covered=%h entries=%0d full=%b uerr=%b",
                                 $time, got.found, got.complete, got.covered,
                                 got.entries, got.full, got.uerr);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
            if (i_in_valid && i_in_ready)
                expected_q.push_back(apply_command(i_cmd, i_offset, i_length));
        end
    end
endmodule
`default_nettype wire

// File: verif/byte_range_coverage_tracker_top_tb.sv
// testbench top for the byte range coverage tracker: clock, reset, stimulus and verdict
// depends on brc_pkg, byte_range_coverage_tracker_top and byte_range_coverage_tracker_checker
`default_nettype none
module byte_range_coverage_tracker_top_tb;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [2:0]  cmd = brc_pkg::CMD_CLEAR;
    logic [47:0] offset = '0;
    logic [47:0] length = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic        found, complete, full, uerr;
    logic [47:0] covered;
    logic [4:0]  entries;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [47:0] cfg_data = '0;
    int          fail_count;
    int          pending;
    logic        calm = 1'b0;
    logic        hold_results = 1'b0;

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    byte_range_coverage_tracker_top i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .o_in_ready(in_ready),
        .i_cmd(cmd), .i_offset(offset), .i_length(length),
        .o_out_valid(out_valid), .i_out_ready(out_ready),
        .o_found(found), .o_complete(complete), .o_covered_bytes(covered),
        .o_entries_used(entries), .o_table_full(full), .o_unlock_error(uerr),
        .i_cfg_valid(cfg_valid), .o_cfg_ready(cfg_ready), .i_cfg_data(cfg_data)
    );

    byte_range_coverage_tracker_checker i_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .i_in_ready(in_ready),
        .i_cmd(cmd), .i_offset(offset), .i_length(length),
        .i_out_valid(out_valid), .i_out_ready(out_ready),
        .i_found(found), .i_complete(complete), .i_covered_bytes(covered),
        .i_entries_used(entries), .i_table_full(full), .i_unlock_error(uerr),
        .i_cfg_valid(cfg_valid), .i_cfg_ready(cfg_ready), .i_cfg_data(cfg_data),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    // result side: random stall bursts, none in the calm tail
    initial begin
        int n;
        forever begin
            @(negedge i_clk);
            if (hold_results) begin
                out_ready <= 1'b0;
                repeat (300) @(negedge i_clk);
            end else if (!calm && $urandom_range(0, 5) == 0) begin
                out_ready <= 1'b0;
                n = $urandom_range(1, 11);
                repeat (n - 1) @(negedge i_clk);
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    // valid stays up after the accept until the next transaction or an idle burst
    task automatic send_txn(logic [2:0] c, logic [47:0] o, logic [47:0] l);
        if (!calm && $urandom_range(0, 7) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(negedge i_clk);
        end
        cmd <= c; offset <= o; length <= l; in_valid <= 1'b1;
        @(posedge i_clk);
        while (!in_ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_size(logic [47:0] v);
        in_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (80) @(negedge i_clk);
        cfg_data <= v; cfg_valid <= 1'b1;
        @(posedge i_clk);
        while (!cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        cfg_valid <= 1'b0;
    endtask

    // mostly small offsets inside a window so ranges collide and merge
    task automatic random_txn(logic [47:0] window);
        logic [2:0]  c;
        logic [47:0] o, l;
        int p;
        p = $urandom_range(0, 99);
        if (p < 60) c = brc_pkg::CMD_ADD;
        else if (p < 80) c = brc_pkg::CMD_CHECK;
        else if (p < 84) c = brc_pkg::CMD_CLEAR;
        else if (p < 91) c = brc_pkg::CMD_LOCK;
        else if (p < 98) c = brc_pkg::CMD_UNLOCK;
        else c = 3'($urandom_range(5, 7));
        if ($urandom_range(0, 19) == 0) begin
            o = 48'({$urandom(), $urandom()});
            l = 48'({$urandom(), $urandom()});
        end else begin
            o = 48'($urandom_range(0, 32'(window)));
            l = 48'($urandom_range(0, 12));
        end
        send_txn(c, o, l);
    endtask

    initial begin
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        write_size(48'd100);
        send_txn(brc_pkg::CMD_ADD, 48'd10, 48'd0);           // zero length ignored
        send_txn(brc_pkg::CMD_ADD, 48'd0, 48'd50);
        send_txn(brc_pkg::CMD_ADD, 48'd50, 48'd50);          // abuts, merges
        send_txn(brc_pkg::CMD_ADD, 48'd20, 48'd5);           // inside existing
        send_txn(brc_pkg::CMD_CHECK, 48'd99, 48'd0);
        send_txn(brc_pkg::CMD_CHECK, 48'd100, 48'd5);
        send_txn(brc_pkg::CMD_CHECK, 48'd200, 48'd0);
        send_txn(brc_pkg::CMD_LOCK, 48'd0, 48'd0);
        send_txn(brc_pkg::CMD_LOCK, 48'd0, 48'd0);
        send_txn(brc_pkg::CMD_UNLOCK, 48'd0, 48'd0);
        send_txn(brc_pkg::CMD_UNLOCK, 48'd0, 48'd0);
        send_txn(brc_pkg::CMD_UNLOCK, 48'd0, 48'd0);         // unlock at zero
        send_txn(3'd7, brc_pkg::FIELD_MAX, brc_pkg::FIELD_MAX);
        // clipped at the top
        send_txn(brc_pkg::CMD_ADD, brc_pkg::FIELD_MAX - 48'd3, brc_pkg::FIELD_MAX);
        send_txn(brc_pkg::CMD_ADD, 48'd0, brc_pkg::FIELD_MAX); // saturating total
        send_txn(brc_pkg::CMD_CLEAR, 48'd0, 48'd0);
        for (int k = 0; k < 17; k++)                         // fill then overflow
            send_txn(brc_pkg::CMD_ADD, 48'(k * 10), 48'd2);
        send_txn(brc_pkg::CMD_ADD, 48'd5, 48'd1);            // touches nothing, table full
        send_txn(brc_pkg::CMD_ADD, 48'd2, 48'd8);            // joins two full-table entries
        for (int k = 0; k < 256; k++) send_txn(brc_pkg::CMD_LOCK, 48'd0, 48'd0);
        for (int k = 0; k < 256; k++) send_txn(brc_pkg::CMD_UNLOCK, 48'd0, 48'd0);
        send_txn(brc_pkg::CMD_CLEAR, 48'd0, 48'd0);

        write_size(48'd0);
        for (int k = 0; k < 300; k++) random_txn(48'd300);
        write_size(brc_pkg::FIELD_MAX);
        for (int k = 0; k < 200; k++) random_txn(48'd120);

        // hold results back long enough for the block to stall its input
        fork
            begin
                hold_results = 1'b1;
                repeat (300) @(negedge i_clk);
                hold_results = 1'b0;
            end
            for (int k = 0; k < 20; k++) random_txn(48'd120);
        join
        in_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);

        write_size(48'd64);
        for (int k = 0; k < 400; k++) random_txn(48'd70);
        write_size(48'({$urandom(), $urandom()}));
        calm = 1'b1;
        for (int k = 0; k < 300; k++) random_txn(48'd200);

        in_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (100) @(negedge i_clk);
        if (fail_count == 0) $display("PASS byte_range_coverage_tracker_top");
        else $display("FAIL byte_range_coverage_tracker_top");
        $finish;
    end

    initial begin
        #20000000;
        $display("FAIL byte_range_coverage_tracker_top");
        $finish;
    end
endmodule
`default_nettype wire

// File: sim.f
+incdir+rtl
rtl/brc_pkg.sv
rtl/brc_ram.sv
rtl/brc_unit.sv
rtl/byte_range_coverage_tracker_top.sv
rtl/brc_checker.sv
verif/byte_range_coverage_tracker_checker.sv
verif/byte_range_coverage_tracker_top_tb.sv
